### hw/rtl/flfv_pkg.sv
// shared constants, types and the crc-32c byte step for the frame validator
`timescale 1ns / 1ps

package flfv_pkg;

    // frame layout
    localparam int HEADER_LENGTH  = 14;
    localparam int TRAILER_LENGTH = 4;
    localparam int COUNT_BITS     = 17;

    // compare width for frame lengths: covers a 32-bit length plus header and trailer
    localparam int CMP_W = 34;

    localparam logic [7:0]  MAGIC_HI      = 8'h53;
    localparam logic [7:0]  MAGIC_LO      = 8'h43;
    localparam logic [7:0]  FRAME_VERSION = 8'h01;
    localparam logic [31:0] CRC_POLY      = 32'h82F6_3B78;
    localparam logic [31:0] CRC_ONES      = 32'hFFFF_FFFF;

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] MAX_FRAME_RESET   = 16'd4096;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4078;
    localparam logic [7:0]  FIRST_TYPE_RESET  = 8'd1;
    localparam logic [7:0]  LAST_TYPE_RESET   = 8'd4;
    localparam logic [7:0]  REQ_TYPE_RESET    = 8'd3;
    localparam logic [7:0]  STATUS_TYPE_RESET = 8'd2;

    // register indexes
    typedef enum logic [2:0] {
        REG_MAX_FRAME   = 3'd0,
        REG_MAX_PAYLOAD = 3'd1,
        REG_FIRST_TYPE  = 3'd2,
        REG_LAST_TYPE   = 3'd3,
        REG_REQ_TYPE    = 3'd4,
        REG_STATUS_TYPE = 3'd5
    } reg_idx_t;

    // frame verdict codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_INVALID = 2'd2,
        ST_CRC     = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic [15:0] max_frame_bytes;
        logic [15:0] max_payload_bytes;
        logic [7:0]  first_type_code;
        logic [7:0]  last_type_code;
        logic [7:0]  request_type_code;
        logic [7:0]  status_type_code;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       receiver_side;
    } byte_item_t;

    // one byte through the reflected crc-32c register, bit at a time
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

### hw/rtl/flfv_if.sv
// valid/ready channels for frame bytes and frame verdicts
`timescale 1ns / 1ps

interface flfv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       receiver_side;

    modport source (output valid, data_byte, last_byte, receiver_side, input ready);
    modport sink   (input valid, data_byte, last_byte, receiver_side, output ready);
endinterface

interface flfv_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [7:0]  msg_type;
    logic [31:0] sequence_number;
    logic [15:0] payload_bytes;

    modport source (output valid, frame_status, msg_type, sequence_number, payload_bytes,
                    input ready);
    modport sink   (input valid, frame_status, msg_type, sequence_number, payload_bytes,
                    output ready);
endinterface

### hw/rtl/flfv_cfg_regs.sv
// apb configuration registers of the frame validator
`timescale 1ns / 1ps

module flfv_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [flfv_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [flfv_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [flfv_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output flfv_pkg::cfg_t                      cfg
);

    flfv_pkg::cfg_t   cfg_reg;
    flfv_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = flfv_pkg::reg_idx_t'(paddr[flfv_pkg::CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_bytes   <= flfv_pkg::MAX_FRAME_RESET;
            cfg_reg.max_payload_bytes <= flfv_pkg::MAX_PAYLOAD_RESET;
            cfg_reg.first_type_code   <= flfv_pkg::FIRST_TYPE_RESET;
            cfg_reg.last_type_code    <= flfv_pkg::LAST_TYPE_RESET;
            cfg_reg.request_type_code <= flfv_pkg::REQ_TYPE_RESET;
            cfg_reg.status_type_code  <= flfv_pkg::STATUS_TYPE_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                flfv_pkg::REG_MAX_FRAME:   cfg_reg.max_frame_bytes   <= pwdata[15:0];
                flfv_pkg::REG_MAX_PAYLOAD: cfg_reg.max_payload_bytes <= pwdata[15:0];
                flfv_pkg::REG_FIRST_TYPE:  cfg_reg.first_type_code   <= pwdata[7:0];
                flfv_pkg::REG_LAST_TYPE:   cfg_reg.last_type_code    <= pwdata[7:0];
                flfv_pkg::REG_REQ_TYPE:    cfg_reg.request_type_code <= pwdata[7:0];
                flfv_pkg::REG_STATUS_TYPE: cfg_reg.status_type_code  <= pwdata[7:0];
                default:                   ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            flfv_pkg::REG_MAX_FRAME:   prdata = {16'h0000, cfg_reg.max_frame_bytes};
            flfv_pkg::REG_MAX_PAYLOAD: prdata = {16'h0000, cfg_reg.max_payload_bytes};
            flfv_pkg::REG_FIRST_TYPE:  prdata = {24'h000000, cfg_reg.first_type_code};
            flfv_pkg::REG_LAST_TYPE:   prdata = {24'h000000, cfg_reg.last_type_code};
            flfv_pkg::REG_REQ_TYPE:    prdata = {24'h000000, cfg_reg.request_type_code};
            flfv_pkg::REG_STATUS_TYPE: prdata = {24'h000000, cfg_reg.status_type_code};
            default:                   prdata = '0;
        endcase
    end

endmodule

### hw/rtl/flfv_frame_check.sv
// frame state, header capture, crc and verdict logic with the result register
`timescale 1ns / 1ps

module flfv_frame_check #(
    parameter int COUNT_BITS = flfv_pkg::COUNT_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  flfv_pkg::cfg_t       cfg,
    input  logic                 step_valid,
    input  flfv_pkg::byte_item_t step,
    output logic                 step_ready,
    flfv_result_if.source        report
);

    localparam int CW = flfv_pkg::CMP_W;

    // frame state
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [31:0]           crc_reg, crc_next;
    logic [7:0]            tail_reg  [flfv_pkg::TRAILER_LENGTH];
    logic [7:0]            tail_next [flfv_pkg::TRAILER_LENGTH];
    logic                  hdr_bad_reg, hdr_bad_next;
    logic [7:0]            type_reg, type_next;
    logic [15:0]           flags_reg, flags_next;
    logic [31:0]           seq_reg, seq_next;
    logic [31:0]           len_reg, len_next;

    // result register
    logic                    res_v_reg;
    flfv_pkg::frame_status_t res_status_reg;
    logic [7:0]              res_type_reg;
    logic [31:0]             res_seq_reg;
    logic [15:0]             res_len_reg;

    logic                    fire;
    logic                    frame_end;
    logic                    out_free;
    logic [7:0]              b;
    logic [CW-1:0]           n_cmp;
    logic [CW-1:0]           expected;
    logic [31:0]             got_crc;
    logic                    type_allowed;
    flfv_pkg::frame_status_t verdict;

    assign b          = step.data_byte;
    assign out_free   = !res_v_reg || report.ready;
    assign step_ready = !step.last_byte || out_free;
    assign fire       = step_valid && step_ready;
    assign frame_end  = fire && step.last_byte;

    // header capture and delay line for the current byte, crc update for the byte leaving the delay line
    always_comb
    begin
        hdr_bad_next = hdr_bad_reg;
        if (count_reg == COUNT_BITS'(0) && b != flfv_pkg::MAGIC_HI)
        begin
            hdr_bad_next = 1'b1;
        end
        if (count_reg == COUNT_BITS'(1) && b != flfv_pkg::MAGIC_LO)
        begin
            hdr_bad_next = 1'b1;
        end
        if (count_reg == COUNT_BITS'(2) && b != flfv_pkg::FRAME_VERSION)
        begin
            hdr_bad_next = 1'b1;
        end

        type_next  = (count_reg == COUNT_BITS'(3)) ? b : type_reg;
        flags_next = (count_reg == COUNT_BITS'(4) || count_reg == COUNT_BITS'(5)) ?
                     {flags_reg[7:0], b} : flags_reg;
        seq_next   = (count_reg >= COUNT_BITS'(6) && count_reg <= COUNT_BITS'(9)) ?
                     {seq_reg[23:0], b} : seq_reg;
        len_next   = (count_reg >= COUNT_BITS'(10) &&
                      count_reg < COUNT_BITS'(flfv_pkg::HEADER_LENGTH)) ?
                     {len_reg[23:0], b} : len_reg;

        crc_next = (count_reg >= COUNT_BITS'(flfv_pkg::TRAILER_LENGTH)) ?
                   flfv_pkg::crc32c_byte(crc_reg, tail_reg[0]) : crc_reg;

        for (int i = 0; i < flfv_pkg::TRAILER_LENGTH - 1; i++)
        begin
            tail_next[i] = tail_reg[i+1];
        end
        tail_next[flfv_pkg::TRAILER_LENGTH-1] = b;

        count_next = (count_reg != '1) ? count_reg + COUNT_BITS'(1) : count_reg;
    end

    // verdict over the frame including this byte
    always_comb
    begin
        n_cmp    = CW'(count_next);
        expected = CW'(flfv_pkg::HEADER_LENGTH) + CW'(len_next) +
                   CW'(flfv_pkg::TRAILER_LENGTH);
        got_crc  = {tail_next[0], tail_next[1], tail_next[2], tail_next[3]};

        if (step.receiver_side)
        begin
            type_allowed = (type_next == cfg.first_type_code) ||
                           (type_next == cfg.status_type_code) ||
                           (type_next == cfg.last_type_code);
        end
        else
        begin
            type_allowed = (type_next == cfg.request_type_code);
        end

        if (n_cmp < CW'(flfv_pkg::HEADER_LENGTH))
            verdict = flfv_pkg::ST_TRUNC;
        else if (n_cmp > CW'(cfg.max_frame_bytes))
            verdict = flfv_pkg::ST_INVALID;
        else if (hdr_bad_next)
            verdict = flfv_pkg::ST_INVALID;
        else if (type_next < cfg.first_type_code || type_next > cfg.last_type_code)
            verdict = flfv_pkg::ST_INVALID;
        else if (!type_allowed)
            verdict = flfv_pkg::ST_INVALID;
        else if (len_next > 32'(cfg.max_payload_bytes))
            verdict = flfv_pkg::ST_INVALID;
        else if (n_cmp < expected)
            verdict = flfv_pkg::ST_TRUNC;
        else if (n_cmp != expected)
            verdict = flfv_pkg::ST_INVALID;
        else if (got_crc != ~crc_next)
            verdict = flfv_pkg::ST_CRC;
        else if (flags_next != 16'h0000)
            verdict = flfv_pkg::ST_INVALID;
        else
            verdict = flfv_pkg::ST_OK;
    end

    // frame state registers, cleared at the end of every frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= flfv_pkg::CRC_ONES;
            hdr_bad_reg <= 1'b0;
            type_reg    <= '0;
            flags_reg   <= '0;
            seq_reg     <= '0;
            len_reg     <= '0;
            for (int i = 0; i < flfv_pkg::TRAILER_LENGTH; i++)
            begin
                tail_reg[i] <= '0;
            end
        end
        else if (frame_end)
        begin
            count_reg   <= '0;
            crc_reg     <= flfv_pkg::CRC_ONES;
            hdr_bad_reg <= 1'b0;
            type_reg    <= '0;
            flags_reg   <= '0;
            seq_reg     <= '0;
            len_reg     <= '0;
            for (int i = 0; i < flfv_pkg::TRAILER_LENGTH; i++)
            begin
                tail_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            hdr_bad_reg <= hdr_bad_next;
            type_reg    <= type_next;
            flags_reg   <= flags_next;
            seq_reg     <= seq_next;
            len_reg     <= len_next;
            for (int i = 0; i < flfv_pkg::TRAILER_LENGTH; i++)
            begin
                tail_reg[i] <= tail_next[i];
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_v_reg <= 1'b0;
        end
        else if (frame_end)
        begin
            res_v_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            res_v_reg <= 1'b0;
        end
    end

    // result payload, fields zero unless the frame is good
    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            res_status_reg <= verdict;
            if (verdict == flfv_pkg::ST_OK)
            begin
                res_type_reg <= type_next;
                res_seq_reg  <= seq_next;
                res_len_reg  <= len_next[15:0];
            end
            else
            begin
                res_type_reg <= '0;
                res_seq_reg  <= '0;
                res_len_reg  <= '0;
            end
        end
    end

    assign report.valid           = res_v_reg;
    assign report.frame_status    = res_status_reg;
    assign report.msg_type        = res_type_reg;
    assign report.sequence_number = res_seq_reg;
    assign report.payload_bytes   = res_len_reg;

    // a new result only appears after a last byte was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_v_reg) |-> $past(frame_end))
        else $error("result valid without a frame end");

    // frame state is back at reset values after a frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (count_reg == '0) && (crc_reg == flfv_pkg::CRC_ONES) && !hdr_bad_reg)
        else $error("frame state not cleared after frame end");

    // a failed frame reports no header fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg && (res_status_reg != flfv_pkg::ST_OK) |->
        (res_type_reg == '0) && (res_seq_reg == '0) && (res_len_reg == '0))
        else $error("header fields leak on a failed frame");

    // the byte count never falls inside a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !step.last_byte |=> count_reg >= $past(count_reg))
        else $error("byte count fell inside a frame");

    // a pending result is never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg && !report.ready |-> !frame_end)
        else $error("result overwritten while stalled");

endmodule

### hw/rtl/framed_link_frame_validator.sv
// path: a last byte passes the input register, then the result register raises result valid
// throughput: one byte per cycle; a last byte waits only while an untaken result occupies
// the result register; the crc byte step and verdict logic are combinational
// reset: rst_n clears frame state and result valid at once, config returns to defaults
// top level of the frame validator: input register, frame check and apb registers
`timescale 1ns / 1ps

module framed_link_frame_validator #(
    parameter int COUNT_BITS = flfv_pkg::COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [flfv_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [flfv_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [flfv_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    flfv_byte_if.sink                        link,
    flfv_result_if.source                    report
);

    flfv_pkg::cfg_t       cfg;
    logic                 in_v_reg;
    flfv_pkg::byte_item_t in_item_reg;
    logic                 step_ready;
    logic                 link_take;

    assign link.ready = !in_v_reg || step_ready;
    assign link_take  = link.valid && link.ready;

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (link_take)
        begin
            in_v_reg <= 1'b1;
        end
        else if (step_ready)
        begin
            in_v_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (link_take)
        begin
            in_item_reg.data_byte     <= link.data_byte;
            in_item_reg.last_byte     <= link.last_byte;
            in_item_reg.receiver_side <= link.receiver_side;
        end
    end

    flfv_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    flfv_frame_check #(
        .COUNT_BITS (COUNT_BITS)
    ) u_frame_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step_valid (in_v_reg),
        .step       (in_item_reg),
        .step_ready (step_ready),
        .report     (report)
    );

endmodule
